// ----- rtl/rdc_pkg.sv -----
// rdc_pkg: shared constants, types and helpers for the radix digit converter.
// No dependencies; imported by rdc_div, radix_digit_converter and the testbench.
package rdc_pkg;

    localparam int MAX_DIGITS  = 32;
    localparam int DIGIT_LIMIT = (MAX_DIGITS < 32) ? MAX_DIGITS : 32;
    localparam int CNT_W       = $clog2(DIGIT_LIMIT + 1);
    localparam int ADDR_W      = $clog2(MAX_DIGITS);

    localparam int VAL_W       = 32;
    localparam int STEP_W      = $clog2(VAL_W);
    localparam int RADIX_W     = 9;
    localparam int MINW_W      = 6;
    localparam int DIGIT_W     = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIX     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 2'd1;

    localparam logic [RADIX_W-1:0] RADIX_RESET = 9'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN   = 9'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX   = 9'd256;
    localparam logic [MINW_W-1:0]  MINW_RESET  = 6'd1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_READ,
        S_LOAD,
        S_WAIT
    } t_state;

    // Clamp the programmed base into 2..256.
    function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
        logic [RADIX_W-1:0] res;
        res = r;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end
        return res;
    endfunction

    // Clamp the programmed minimum width into 1..DIGIT_LIMIT.
    function automatic logic [CNT_W-1:0] eff_min_width(input logic [MINW_W-1:0] w);
        logic [CNT_W-1:0] res;
        if (w == '0) begin
            res = CNT_W'(1);
        end else if (int'(w) > DIGIT_LIMIT) begin
            res = CNT_W'(DIGIT_LIMIT);
        end else begin
            res = CNT_W'(w);
        end
        return res;
    endfunction

endpackage

// ----- rtl/rdc_ram.sv -----
// rdc_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rdc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/rdc_div.sv -----
// rdc_div: restoring divider, one quotient bit per cycle, 32-bit dividend by
// a 9-bit base. Depends on rdc_pkg.
module rdc_div
    import rdc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [VAL_W-1:0]   i_dividend,
    input  logic [RADIX_W-1:0] i_divisor,
    output logic               o_done,
    output logic [VAL_W-1:0]   o_quotient,
    output logic [DIGIT_W-1:0] o_remainder
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [STEP_W-1:0]  r_cnt, n_cnt;
    logic [VAL_W-1:0]   r_quo, n_quo;
    logic [DIGIT_W-1:0] r_rem, n_rem;
    logic [RADIX_W-1:0] r_dsr, n_dsr;

    logic [RADIX_W-1:0] shifted;
    logic               ge;
    logic [RADIX_W-1:0] diff;

    // remainder stays below the base (<= 256), so the shifted value fits 9 bits
    assign shifted = {r_rem, r_quo[VAL_W-1]};
    assign ge      = (shifted >= r_dsr);
    assign diff    = shifted - r_dsr;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            n_rem = ge ? diff[DIGIT_W-1:0] : shifted[DIGIT_W-1:0];
            n_quo = {r_quo[VAL_W-2:0], ge};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(VAL_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/radix_digit_converter.sv -----
// radix_digit_converter: top level; sequencer, configuration registers and
// output register. Depends on rdc_pkg, rdc_div and rdc_ram.
//
// Converts one signed 32-bit request into zero-padded digits of the
// programmed base (radix 2..256, out-of-range codes clamp), most significant
// first, with o_last on the final digit. Zero or negative values give only
// zeros. The emitted width is max(current width, digit count); the current
// width is reloaded from min_width on a write to that register and then only
// grows. One request at a time: each significant digit goes through the
// shared bit-serial divider (its steps plus start and write-back), and
// each emitted digit goes through the digit buffer's registered read
// before it is offered. Configuration writes are taken only while the
// block is idle.
module radix_digit_converter
    import rdc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [VAL_W-1:0]      i_value,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [DIGIT_W-1:0]    o_digit,
    output logic                  o_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_state             r_state, n_state;
    logic [RADIX_W-1:0] r_radix, n_radix;
    logic [CNT_W-1:0]   r_cur_width, n_cur_width;
    logic [VAL_W-1:0]   r_u, n_u;
    logic [CNT_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_pos, n_pos;
    logic               r_out_valid, n_out_valid;
    logic [DIGIT_W-1:0] r_digit, n_digit;
    logic               r_last, n_last;

    logic               div_start;
    logic               div_done;
    logic [VAL_W-1:0]   div_quo;
    logic [DIGIT_W-1:0] div_rem;
    logic               ram_we;
    logic [DIGIT_W-1:0] ram_rdata;
    logic               cfg_wr;
    logic [CNT_W-1:0]   width_sel;

    assign o_cfg_ready = (r_state == S_IDLE);
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign width_sel   = (r_len > r_cur_width) ? r_len : r_cur_width;

    rdc_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_u),
        .i_divisor   (eff_radix(r_radix)),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (MAX_DIGITS)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_len[ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_raddr (r_pos[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_radix     = r_radix;
        n_cur_width = r_cur_width;
        n_u         = r_u;
        n_len       = r_len;
        n_pos       = r_pos;
        n_out_valid = r_out_valid;
        n_digit     = r_digit;
        n_last      = r_last;
        div_start   = 1'b0;
        ram_we      = 1'b0;

        if (cfg_wr) begin
            case (i_cfg_index)
                CFG_RADIX: begin
                    n_radix = i_cfg_data[RADIX_W-1:0];
                end
                CFG_MIN_WIDTH: begin
                    n_cur_width = eff_min_width(i_cfg_data[MINW_W-1:0]);
                end
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // only strictly positive values produce significant digits
                    n_u     = i_value[VAL_W-1] ? '0 : i_value;
                    n_len   = '0;
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_u != '0 && r_len < CNT_W'(DIGIT_LIMIT)) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end else begin
                    n_cur_width = width_sel;
                    n_pos       = width_sel - CNT_W'(1);
                    n_state     = S_READ;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    ram_we  = 1'b1;
                    n_u     = div_quo;
                    n_len   = r_len + CNT_W'(1);
                    n_state = S_CHECK;
                end
            end
            S_READ: begin
                n_state = S_LOAD;
            end
            S_LOAD: begin
                // positions past the digit run are leading zero padding
                n_digit     = (r_pos < r_len) ? ram_rdata : '0;
                n_last      = (r_pos == '0);
                n_out_valid = 1'b1;
                n_state     = S_WAIT;
            end
            S_WAIT: begin
                if (i_out_ready) begin
                    n_out_valid = 1'b0;
                    if (r_pos == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_pos   = r_pos - CNT_W'(1);
                        n_state = S_READ;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_RESET;
            r_cur_width <= eff_min_width(MINW_RESET);
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_radix     <= n_radix;
            r_cur_width <= n_cur_width;
            r_len       <= n_len;
            r_out_valid <= n_out_valid;
        end
        r_u     <= n_u;
        r_pos   <= n_pos;
        r_digit <= n_digit;
        r_last  <= n_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_digit     = r_digit;
    assign o_last      = r_last;

    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !o_out_valid)
        else $error("input ready while a digit is pending");

    a_width_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cur_width != '0) && (r_cur_width <= CNT_W'(DIGIT_LIMIT)))
        else $error("current width out of range");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_u != '0) && (r_len < CNT_W'(DIGIT_LIMIT)))
        else $error("division started without significant digits left");

    a_pos_in_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (r_pos < r_cur_width) && (r_len <= r_cur_width))
        else $error("emitted position outside the current width");

endmodule

// ----- sim/testbench.sv -----
// testbench: self-checking bench for radix_digit_converter (digits of a signed
// value in a programmable base). Depends on rdc_pkg and the RTL under rtl/.
// Directed table first (typed digits where given, else the predictor), then random phases checked against a predictor.
module testbench
    import rdc_pkg::*;
();

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int HOLD_CYCLES   = 3000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 100;
    localparam int NPLAN         = 39;

    typedef enum logic {ROW_CFG, ROW_VAL} t_row_kind;

    // typed_len == 0 means the row is checked against the predictor only
    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
        logic [VAL_W-1:0]      value;
        logic [5:0]            typed_len;
        logic [95:0]           typed_digits;
    } t_plan_row;

    typedef struct {
        logic [DIGIT_W-1:0] digit;
        logic               last;
    } t_digit_beat;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [VAL_W-1:0]      i_value = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic [DIGIT_W-1:0]    o_digit;
    logic                  o_last;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // shadow of the block's registers and width state
    logic [RADIX_W-1:0]    shadow_radix = RADIX_RESET;
    logic [MINW_W-1:0]     shadow_min_width = MINW_RESET;
    int                    run_width = 1;
    logic [DIGIT_W-1:0]    pred_digit [0:DIGIT_LIMIT-1];
    int                    pred_count;

    t_digit_beat           want_digits [$];
    int                    fail_count = 0;
    bit                    hold_armed = 1'b0;

    t_plan_row plan [0:NPLAN-1] = '{
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h0000_0000, 6'd1,  96'h00},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'hFFFF_FFFF, 6'd1,  96'h00},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h8000_0000, 6'd1,  96'h00},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd7,         6'd1,  96'h07},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h7FFF_FFFF, 6'd10,
          96'h02_01_04_07_04_08_03_06_04_07},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd5,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd1,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd1,         6'd1,  96'h01},
        '{ROW_CFG, CFG_RADIX,     9'd0,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd5,         6'd3,  96'h01_00_01},
        '{ROW_CFG, CFG_RADIX,     9'd1,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h7FFF_FFFF, 6'd0,  96'h0},
        '{ROW_CFG, CFG_RADIX,     9'd256, 32'd0,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd1,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h7FFF_FFFF, 6'd4,  96'h7F_FF_FF_FF},
        '{ROW_CFG, CFG_RADIX,     9'd511, 32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h1234_5678, 6'd4,  96'h12_34_56_78},
        '{ROW_CFG, CFG_RADIX,     9'd257, 32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd255,       6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd32,  32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd1,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd63,  32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd0,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd0,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd2,         6'd1,  96'h02},
        '{ROW_CFG, CFG_SPARE_A,   9'h1FF, 32'd0,         6'd0,  96'h0},
        '{ROW_CFG, CFG_SPARE_B,   9'd0,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd3,         6'd1,  96'h03},
        '{ROW_CFG, CFG_RADIX,     9'd3,   32'd0,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'h1C5, 32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'd100,       6'd0,  96'h0},
        '{ROW_CFG, CFG_RADIX,     9'd36,  32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h7FFF_FFFF, 6'd0,  96'h0},
        '{ROW_CFG, CFG_RADIX,     9'd255, 32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h7FFF_FFFF, 6'd0,  96'h0},
        '{ROW_CFG, CFG_RADIX,     9'd16,  32'd0,         6'd0,  96'h0},
        '{ROW_CFG, CFG_MIN_WIDTH, 9'd8,   32'd0,         6'd0,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'hDEAD_BEEF, 6'd8,  96'h0},
        '{ROW_VAL, CFG_RADIX,     9'd0,   32'h0ACE_1234, 6'd8,
          96'h00_0A_0C_0E_01_02_03_04}
    };

    radix_digit_converter uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_value     (i_value),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_digit     (o_digit),
        .o_last      (o_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #60_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_count++;
    endtask

    // Digits of v in the shadow base, padded to the running width, msb first.
    function automatic void convert_to_digits(input logic [VAL_W-1:0] v);
        logic [31:0]        u;
        logic [31:0]        base;
        logic [DIGIT_W-1:0] lsd_first [0:DIGIT_LIMIT-1];
        int                 len;
        if (shadow_radix < 2) begin
            base = 2;
        end else if (shadow_radix > 256) begin
            base = 256;
        end else begin
            base = 32'(shadow_radix);
        end
        u = v[VAL_W-1] ? '0 : v;
        len = 0;
        while (u != 0 && len < DIGIT_LIMIT) begin
            lsd_first[len] = DIGIT_W'(u % base);
            u = u / base;
            len++;
        end
        if (len > run_width) run_width = len;
        if (run_width > DIGIT_LIMIT) run_width = DIGIT_LIMIT;
        for (int i = len; i < run_width; i++) lsd_first[i] = '0;
        pred_count = run_width;
        for (int i = 0; i < run_width; i++) pred_digit[i] = lsd_first[run_width - 1 - i];
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_RADIX: begin
                shadow_radix = data;
            end
            CFG_MIN_WIDTH: begin
                shadow_min_width = data[MINW_W-1:0];
                if (shadow_min_width == 0) begin
                    run_width = 1;
                end else if (int'(shadow_min_width) > DIGIT_LIMIT) begin
                    run_width = DIGIT_LIMIT;
                end else begin
                    run_width = int'(shadow_min_width);
                end
            end
            default: ;
        endcase
    endfunction

    function automatic int pick_gap();
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 40) gap = 0;
        else if (r < 85) gap = $urandom_range(1, 3);
        else if (r < 97) gap = $urandom_range(4, 12);
        else gap = $urandom_range(30, 100);
        return gap;
    endfunction

    function automatic logic [VAL_W-1:0] pick_value();
        int               r;
        logic [VAL_W-1:0] v;
        r = $urandom_range(0, 99);
        // mostly positive values of random magnitude, so digit counts vary
        if (r < 70) v = ($urandom & 32'h7FFF_FFFF) >> $urandom_range(0, 31);
        else if (r < 78) v = '0;
        else if (r < 84) v = 32'h7FFF_FFFF;
        else if (r < 94) v = $urandom | 32'h8000_0000;
        else v = $urandom;
        return v;
    endfunction

    task automatic send_value(input logic [VAL_W-1:0] v, input logic [5:0] tlen,
                              input logic [95:0] tdig);
        int          gap;
        t_digit_beat beat;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_value    <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        convert_to_digits(v);
        if (tlen != 0) begin
            for (int i = 0; i < tlen; i++) begin
                beat.digit = tdig[8 * (tlen - 1 - i) +: 8];
                beat.last  = (i == tlen - 1);
                want_digits.insert(want_digits.size(), beat);
            end
        end else begin
            for (int i = 0; i < pred_count; i++) begin
                beat.digit = pred_digit[i];
                beat.last  = (i == pred_count - 1);
                want_digits.insert(want_digits.size(), beat);
            end
        end
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Stop offering requests and let every expected digit come out.
    task automatic wait_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (want_digits.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic check_digit();
        t_digit_beat beat;
        if (want_digits.size() == 0) begin
            report_mismatch($sformatf("digit %0d last %0b with nothing pending",
                                      o_digit, o_last));
        end else begin
            beat = want_digits.pop_front();
            if (o_digit !== beat.digit)
                report_mismatch($sformatf("digit %0d, predicted %0d", o_digit, beat.digit));
            if (o_last !== beat.last)
                report_mismatch($sformatf("last %0b, predicted %0b", o_last, beat.last));
        end
    endtask

    // output side: random stalls, quiet stretches, one long hold-off
    initial begin
        int stall_left;
        int steady_left;
        int r;
        stall_left  = 0;
        steady_left = 0;
        forever begin
            @(negedge i_clk);
            if (hold_armed && o_out_valid) begin
                i_out_ready <= 1'b0;
                hold_armed = 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (stall_left > 0) begin
                    i_out_ready <= 1'b0;
                    stall_left--;
                end else if (steady_left > 0) begin
                    i_out_ready <= 1'b1;
                    steady_left--;
                end else begin
                    r = $urandom_range(0, 99);
                    if (r < 60) begin
                        i_out_ready <= 1'b1;
                    end else if (r < 65) begin
                        i_out_ready <= 1'b1;
                        steady_left = $urandom_range(50, 300);
                    end else if (r < 88) begin
                        i_out_ready <= 1'b0;
                        stall_left = $urandom_range(0, 2);
                    end else if (r < 98) begin
                        i_out_ready <= 1'b0;
                        stall_left = $urandom_range(3, 15);
                    end else begin
                        i_out_ready <= 1'b0;
                        stall_left = $urandom_range(30, 120);
                    end
                end
                @(posedge i_clk);
                if (o_out_valid && i_out_ready) check_digit();
            end
        end
    end

    initial begin
        int                    random_sent;
        int                    phase_items;
        bit                    first_phase;
        logic [CFG_DATA_W-1:0] radix_data;
        logic [CFG_DATA_W-1:0] width_data;
        random_sent = 0;
        first_phase = 1'b1;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < NPLAN; k++) begin
            if (plan[k].kind == ROW_CFG) begin
                wait_drain();
                write_register(plan[k].index, plan[k].data);
            end else begin
                send_value(plan[k].value, plan[k].typed_len, plan[k].typed_digits);
            end
        end

        while (random_sent < RANDOM_ITEMS) begin
            wait_drain();
            case ($urandom_range(0, 9))
                0: radix_data = CFG_DATA_W'($urandom_range(0, 1));
                1: radix_data = 9'd2;
                2: radix_data = 9'd256;
                3: radix_data = CFG_DATA_W'($urandom_range(257, 511));
                default: radix_data = CFG_DATA_W'($urandom_range(2, 255));
            endcase
            // upper data bits beyond the width field are don't-care
            case ($urandom_range(0, 7))
                0: width_data = CFG_DATA_W'($urandom_range(0, 7) << 6);
                1: width_data = CFG_DATA_W'($urandom_range(32, 511));
                default: width_data = CFG_DATA_W'($urandom_range(1, 6)
                                                  | ($urandom_range(0, 7) << 6));
            endcase
            if ($urandom_range(0, 1)) begin
                write_register(CFG_RADIX, radix_data);
                write_register(CFG_MIN_WIDTH, width_data);
            end else begin
                write_register(CFG_MIN_WIDTH, width_data);
                write_register(CFG_RADIX, radix_data);
            end
            if ($urandom_range(0, 3) == 0)
                write_register($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                               CFG_DATA_W'($urandom));
            // first phase: hold the output side while requests keep coming
            if (first_phase) begin
                hold_armed  = 1'b1;
                first_phase = 1'b0;
            end
            phase_items = $urandom_range(10, 20);
            if (phase_items > RANDOM_ITEMS - random_sent)
                phase_items = RANDOM_ITEMS - random_sent;
            repeat (phase_items) begin
                send_value(pick_value(), 6'd0, 96'h0);
                random_sent++;
            end
        end

        wait_drain();
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
